[design/multi_queue_overwrite_fifo_core_defines.svh]
// assertion macros for the multi-queue overwrite fifo rtl
// no dependencies; users supply i_clk and i_rst_n in scope
`ifndef MULTI_QUEUE_OVERWRITE_FIFO_CORE_DEFINES_SVH
`define MULTI_QUEUE_OVERWRITE_FIFO_CORE_DEFINES_SVH

// checked only while out of reset
`define MQOF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MQOF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/mqof_pkg.sv]
// shared types and codes for the multi-queue overwrite fifo
// no dependencies
`timescale 1ns / 1ps

package mqof_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int LOST_W = 32;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_READ  = 2'd1;
    localparam t_cmd CMD_WRITE = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_LOST  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[design/mqof_ctrl.sv]
// request sequencer for the multi-queue overwrite fifo
// depends on mqof_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "multi_queue_overwrite_fifo_core_defines.svh"

module mqof_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_valid,
    output mqof_pkg::t_dp_cmd o_dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_RESP);
    assign o_dp_cmd.load = start && (r_state == S_IDLE);
    assign o_dp_cmd.exec = (r_state == S_EXEC);

    `MQOF_ASSERT(a_accept_to_result, start && !busy |-> ##2 o_valid, "request lost")
    `MQOF_ASSERT(a_result_single, o_valid |=> !o_valid, "result repeated")
    `MQOF_ASSERT(a_free_after_result, o_valid |=> !busy, "stuck busy after result")
    `MQOF_ASSERT_ALWAYS(a_result_while_busy, o_valid |-> busy, "result while idle")

endmodule

[design/mqof_dp.sv]
// queue pointers, counters and word memory of the multi-queue overwrite fifo
// depends on mqof_pkg
`timescale 1ns / 1ps

module mqof_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_QUEUES  = 4,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mqof_pkg::t_dp_cmd             i_dp_cmd,
    input  logic [mqof_pkg::CMD_W-1:0]    i_command,
    input  logic [mqof_pkg::IDX_W-1:0]    i_queue_index,
    input  logic [mqof_pkg::DATA_W-1:0]   i_write_data,
    output logic [mqof_pkg::DATA_W-1:0]   o_read_data,
    output logic [mqof_pkg::STAT_W-1:0]   o_status,
    output logic [mqof_pkg::OCC_W-1:0]    o_occupancy,
    output logic [mqof_pkg::LOST_W-1:0]   o_lost_count
);

    localparam int DW = (WORD_WIDTH < mqof_pkg::DATA_W) ? WORD_WIDTH : mqof_pkg::DATA_W;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW = (QW > mqof_pkg::IDX_W) ? QW : mqof_pkg::IDX_W;
    localparam int MD = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    // captured request
    mqof_pkg::t_cmd               r_cmd;
    logic [mqof_pkg::IDX_W-1:0]   r_idx;
    logic [DW-1:0]                r_wdata;

    // per-queue state
    logic [PW-1:0]                r_rd_ptr [NUM_QUEUES];
    logic [PW-1:0]                r_wr_ptr [NUM_QUEUES];
    logic [FW-1:0]                r_fill   [NUM_QUEUES];
    logic [mqof_pkg::LOST_W-1:0]  r_lost   [NUM_QUEUES];

    logic [DW-1:0]                mem [MD];
    logic [DW-1:0]                r_rd_data;
    logic                         r_rd_hit;
    mqof_pkg::t_status            r_status;
    logic [mqof_pkg::OCC_W-1:0]   r_occ;
    logic [mqof_pkg::LOST_W-1:0]  r_lost_out;

    logic [IW-1:0]                idx_ext;
    logic [QW-1:0]                q_sel;
    logic                         q_ok;
    logic [PW-1:0]                cur_rd;
    logic [PW-1:0]                cur_wr;
    logic [FW-1:0]                cur_fill;
    logic [mqof_pkg::LOST_W-1:0]  cur_lost;
    logic [PW-1:0]                rd_adv;
    logic [PW-1:0]                wr_adv;
    logic [PW-1:0]                n_rd;
    logic [PW-1:0]                n_wr;
    logic [FW-1:0]                n_fill;
    logic [mqof_pkg::LOST_W-1:0]  n_lost;
    mqof_pkg::t_status            n_status;
    logic                         mem_we;
    logic                         rd_hit;
    logic [AW-1:0]                addr_rd;
    logic [AW-1:0]                addr_wr;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd   <= i_command;
            r_idx   <= i_queue_index;
            r_wdata <= DW'(i_write_data);
        end
    end

    assign idx_ext  = IW'(r_idx);
    assign q_sel    = idx_ext[QW-1:0];
    assign q_ok     = (32'(r_idx) < 32'(NUM_QUEUES));
    assign cur_rd   = r_rd_ptr[q_sel];
    assign cur_wr   = r_wr_ptr[q_sel];
    assign cur_fill = r_fill[q_sel];
    assign cur_lost = r_lost[q_sel];
    assign rd_adv   = (cur_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(cur_rd + 1'b1);
    assign wr_adv   = (cur_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(cur_wr + 1'b1);
    assign addr_rd  = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(cur_rd);
    assign addr_wr  = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(cur_wr);

    always_comb begin
        n_rd     = cur_rd;
        n_wr     = cur_wr;
        n_fill   = cur_fill;
        n_lost   = cur_lost;
        n_status = mqof_pkg::ST_OK;
        mem_we   = 1'b0;
        rd_hit   = 1'b0;
        case (r_cmd)
            mqof_pkg::CMD_CLEAR: begin
                n_rd   = '0;
                n_wr   = '0;
                n_fill = '0;
                n_lost = '0;
            end
            mqof_pkg::CMD_READ: begin
                if (cur_fill == '0) begin
                    n_status = mqof_pkg::ST_EMPTY;
                end else begin
                    rd_hit = 1'b1;
                    n_rd   = rd_adv;
                    n_fill = FW'(cur_fill - 1'b1);
                end
            end
            mqof_pkg::CMD_WRITE: begin
                mem_we = 1'b1;
                n_wr   = wr_adv;
                if (cur_fill == FW'(QUEUE_DEPTH)) begin
                    // full: drop the oldest word
                    n_rd     = rd_adv;
                    n_status = mqof_pkg::ST_LOST;
                    if (cur_lost != '1) begin
                        n_lost = cur_lost + 1'b1;
                    end
                end else begin
                    n_fill = FW'(cur_fill + 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_rd_ptr[i] <= '0;
                r_wr_ptr[i] <= '0;
                r_fill[i]   <= '0;
                r_lost[i]   <= '0;
            end
        end else if (i_dp_cmd.exec && q_ok) begin
            r_rd_ptr[q_sel] <= n_rd;
            r_wr_ptr[q_sel] <= n_wr;
            r_fill[q_sel]   <= n_fill;
            r_lost[q_sel]   <= n_lost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec && q_ok && mem_we) begin
            mem[addr_wr] <= r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            r_rd_data <= mem[addr_rd];
        end
    end

    // result fields, all zero for an out-of-range queue
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec) begin
            r_rd_hit   <= q_ok && rd_hit;
            r_status   <= q_ok ? n_status : mqof_pkg::ST_OK;
            r_occ      <= q_ok ? mqof_pkg::OCC_W'(n_fill) : '0;
            r_lost_out <= q_ok ? n_lost : '0;
        end
    end

    assign o_read_data  = r_rd_hit ? mqof_pkg::DATA_W'(r_rd_data) : '0;
    assign o_status     = r_status;
    assign o_occupancy  = r_occ;
    assign o_lost_count = r_lost_out;

endmodule

[design/multi_queue_overwrite_fifo_core.sv]
// top level of the multi-queue overwrite fifo: sequencer plus datapath
// depends on mqof_pkg, mqof_ctrl and mqof_dp
`timescale 1ns / 1ps

// channel   handshake          payload
// request   start, busy        i_command, i_queue_index, i_write_data
// result    o_valid (strobe)   o_read_data, o_status, o_occupancy, o_lost_count
//
// each request goes through capture, queue update with memory access, then result
// the word memory, with one write port and one registered read port, sets the exec step
// busy stays high from accept until the result cycle ends
// synchronous active-low reset clears all pointers, fill and lost counts
// o_valid is high for one cycle and the receiver cannot stall it

module multi_queue_overwrite_fifo_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_QUEUES  = 4,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mqof_pkg::CMD_W-1:0]    i_command,
    input  logic [mqof_pkg::IDX_W-1:0]    i_queue_index,
    input  logic [mqof_pkg::DATA_W-1:0]   i_write_data,
    output logic                          o_valid,
    output logic [mqof_pkg::DATA_W-1:0]   o_read_data,
    output logic [mqof_pkg::STAT_W-1:0]   o_status,
    output logic [mqof_pkg::OCC_W-1:0]    o_occupancy,
    output logic [mqof_pkg::LOST_W-1:0]   o_lost_count
);

    mqof_pkg::t_dp_cmd dp_cmd;

    mqof_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_dp_cmd (dp_cmd)
    );

    mqof_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .i_command     (i_command),
        .i_queue_index (i_queue_index),
        .i_write_data  (i_write_data),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy),
        .o_lost_count  (o_lost_count)
    );

endmodule

[test/mqof_result_checker.sv]
// result checker for the multi-queue overwrite fifo: tracks the queues, predicts
// each result and compares it with what the block returns; depends on mqof_pkg
`timescale 1ns / 1ps

module mqof_result_checker
    import mqof_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_QUEUES  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [IDX_W-1:0]    i_queue_index,
    input  logic [DATA_W-1:0]   i_write_data,
    input  logic                i_valid,
    input  logic [DATA_W-1:0]   i_read_data,
    input  logic [STAT_W-1:0]   i_status,
    input  logic [OCC_W-1:0]    i_occupancy,
    input  logic [LOST_W-1:0]   i_lost_count,
    output int                  o_errors,
    output int                  o_pending
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        t_status           status;
        logic [OCC_W-1:0]  occupancy;
        logic [LOST_W-1:0] lost_count;
    } t_fifo_result;

    logic [DATA_W-1:0] word_mem   [NUM_QUEUES][QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_ptr   [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_ptr   [NUM_QUEUES];
    logic [OCC_W-1:0]  fill_level [NUM_QUEUES];
    logic [LOST_W-1:0] lost_words [NUM_QUEUES];

    t_fifo_result expected_results[$];
    int           mismatch_count = 0;

    assign o_errors = mismatch_count;

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // updates the tracked queue state and returns the result the block owes
    function automatic t_fifo_result apply_command(t_cmd cmd, int q, logic [DATA_W-1:0] data);
        t_fifo_result res;
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                head_ptr[q]   = '0;
                tail_ptr[q]   = '0;
                fill_level[q] = '0;
                lost_words[q] = '0;
            end
            CMD_READ: begin
                if (fill_level[q] == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_data = word_mem[q][head_ptr[q]];
                    head_ptr[q]   = next_slot(head_ptr[q]);
                    fill_level[q] = fill_level[q] - 1'b1;
                end
            end
            CMD_WRITE: begin
                // full queue drops its oldest word
                if (fill_level[q] >= OCC_W'(QUEUE_DEPTH)) begin
                    head_ptr[q] = next_slot(head_ptr[q]);
                    if (lost_words[q] != '1)
                        lost_words[q] = lost_words[q] + 1'b1;
                    res.status = ST_LOST;
                end else begin
                    fill_level[q] = fill_level[q] + 1'b1;
                end
                word_mem[q][tail_ptr[q]] = data;
                tail_ptr[q] = next_slot(tail_ptr[q]);
            end
            default: ;
        endcase
        res.occupancy  = fill_level[q];
        res.lost_count = lost_words[q];
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                head_ptr[q]   = '0;
                tail_ptr[q]   = '0;
                fill_level[q] = '0;
                lost_words[q] = '0;
            end
            expected_results.delete();
        end else begin
            // a result strobed at this edge always belongs to an earlier request
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h %h %h %h",
                             $time, i_read_data, i_status, i_occupancy, i_lost_count);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", 64'(want.read_data), 64'(i_read_data));
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("occupancy", 64'(want.occupancy), 64'(i_occupancy));
                    check_field("lost_count", 64'(want.lost_count), 64'(i_lost_count));
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_command(i_command, int'(i_queue_index),
                                                         i_write_data));
        end
        o_pending <= expected_results.size();
    end

endmodule

[test/tb_multi_queue_overwrite_fifo_core.sv]
// testbench top for multi_queue_overwrite_fifo_core: directed and random requests
// with sender gaps; depends on mqof_pkg, the rtl and mqof_result_checker
`timescale 1ns / 1ps

module tb_multi_queue_overwrite_fifo_core;
    import mqof_pkg::*;

    localparam int   QUEUE_DEPTH    = 16;
    localparam int   NUM_QUEUES     = 4;
    localparam t_cmd CMD_UNUSED     = 2'd3;
    localparam int   PHASE_ITEMS    = 600;
    localparam int   DRAIN_CYCLES   = 12;
    localparam int   WATCHDOG_LIMIT = 1000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  i_command = '0;
    logic [IDX_W-1:0]  i_queue_index = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_valid;
    logic [DATA_W-1:0] o_read_data;
    logic [STAT_W-1:0] o_status;
    logic [OCC_W-1:0]  o_occupancy;
    logic [LOST_W-1:0] o_lost_count;

    int error_count;
    int pending_results;
    int idle_pct;
    int stall_cycles;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    multi_queue_overwrite_fifo_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES),
        .WORD_WIDTH  (DATA_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_queue_index (i_queue_index),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy),
        .o_lost_count  (o_lost_count)
    );

    mqof_result_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_command     (i_command),
        .i_queue_index (i_queue_index),
        .i_write_data  (i_write_data),
        .i_valid       (o_valid),
        .i_read_data   (o_read_data),
        .i_status      (o_status),
        .i_occupancy   (o_occupancy),
        .i_lost_count  (o_lost_count),
        .o_errors      (error_count),
        .o_pending     (pending_results)
    );

    // holds the request, offering it each cycle with random gaps, until accepted
    task automatic send_request(t_cmd cmd, logic [IDX_W-1:0] q, logic [DATA_W-1:0] data);
        i_command     <= cmd;
        i_queue_index <= q;
        i_write_data  <= data;
        start         <= ($urandom_range(0, 99) >= idle_pct);
        @(posedge i_clk);
        while (!(start && !busy)) begin
            start <= ($urandom_range(0, 99) >= idle_pct);
            @(posedge i_clk);
        end
    endtask

    // write share is redrawn every 40 requests so queues both fill and drain
    task automatic send_random_requests(int count);
        int   write_pct;
        int   roll;
        t_cmd cmd;
        logic [DATA_W-1:0] data;
        write_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: write_pct = 25;
                    1: write_pct = 50;
                    default: write_pct = 85;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = CMD_UNUSED;
            else if (roll < 7)
                cmd = CMD_CLEAR;
            else if (roll < 7 + write_pct * 93 / 100)
                cmd = CMD_WRITE;
            else
                cmd = CMD_READ;
            case ($urandom_range(0, 9))
                0: data = '0;
                1: data = '1;
                default: data = $urandom;
            endcase
            send_request(cmd, IDX_W'($urandom_range(0, NUM_QUEUES - 1)), data);
        end
    endtask

    initial begin
        idle_pct = 34;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data extremes, empty read, unused code, clear of a non-empty queue
        send_request(CMD_WRITE, 2'd0, 32'h0000_0000);
        send_request(CMD_WRITE, 2'd0, 32'hFFFF_FFFF);
        send_request(CMD_READ, 2'd0, $urandom);
        send_request(CMD_READ, 2'd2, $urandom);
        send_request(CMD_UNUSED, 2'd0, $urandom);
        send_request(CMD_CLEAR, 2'd0, $urandom);
        // one past full overwrites the oldest word
        for (int n = 0; n <= QUEUE_DEPTH; n++)
            send_request(CMD_WRITE, 2'd3, $urandom);
        send_request(CMD_READ, 2'd3, $urandom);

        send_random_requests(PHASE_ITEMS);
        idle_pct = 59;
        send_random_requests(PHASE_ITEMS);
        idle_pct = 0;
        send_random_requests(PHASE_ITEMS);

        start <= 1'b0;
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t ns: no request or result accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
